// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL; ffca_ctrl.sv includes them.
// Each macro expects a clock named clk and an active-low reset named rst_n
// in the module where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold.
`define FFCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the cycle after.
`define FFCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ffca_pkg.sv =====
`default_nettype none

package ffca_pkg;

  // Field widths of the channels
  localparam int AMT_W      = 32;
  localparam int SLOT_IDX_W = 10;
  localparam int SLOT_W     = 11;
  localparam int CNT_W      = 11;

  // Default number of slots and reset value of the slot count register
  localparam int DEF_MAX_SLOTS = 1024;
  localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

  // Request type codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // Result of the shared subtract/compare unit
  typedef struct packed {
    logic             ge;
    logic [AMT_W-1:0] diff;
    logic [AMT_W-1:0] maxv;
  } alu_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/ffca_if.sv =====
`default_nettype none

// Input item channel
interface ffca_in_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [ffca_pkg::SLOT_IDX_W-1:0]  slot_index;
  logic [ffca_pkg::AMT_W-1:0]       amount;

  modport source (output valid, output req_type, output slot_index, output amount,
                  input ready);
  modport sink   (input valid, input req_type, input slot_index, input amount,
                  output ready);
endinterface

// Result channel
interface ffca_out_if;
  logic                         valid;
  logic                         ready;
  logic [ffca_pkg::SLOT_W-1:0]  assigned_slot;

  modport source (output valid, output assigned_slot, input ready);
  modport sink   (input valid, input assigned_slot, output ready);
endinterface

// Configuration write channel
interface ffca_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ffca_pkg::CNT_W-1:0]  slot_count;

  modport source (output valid, output slot_count, input ready);
  modport sink   (input valid, input slot_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ffca_alu.sv =====
`default_nettype none

module ffca_alu (
  input  wire logic [ffca_pkg::AMT_W-1:0] a,
  input  wire logic [ffca_pkg::AMT_W-1:0] b,
  output ffca_pkg::alu_res_t               res
);

  logic [ffca_pkg::AMT_W:0] wide_diff;

  // One subtractor serves compare, max and subtract
  assign wide_diff = {1'b0, a} - {1'b0, b};
  assign res.ge    = ~wide_diff[ffca_pkg::AMT_W];
  assign res.diff  = wide_diff[ffca_pkg::AMT_W-1:0];
  assign res.maxv  = res.ge ? a : b;

endmodule

`default_nettype wire

// ===== rtl/core/ffca_tree_mem.sv =====
`default_nettype none

module ffca_tree_mem #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];
  logic [DATA_W-1:0] rdata_r;

  // Write one node, read one node with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/ffca_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"

module ffca_ctrl #(
  parameter int MAX_SLOTS = ffca_pkg::DEF_MAX_SLOTS,
  parameter int NODE_W    = $clog2(MAX_SLOTS) + 1,
  parameter int CMP_W     = 11
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  ffca_in_if.sink                          in_ch,
  ffca_out_if.source                       out_ch,
  input  wire logic [CMP_W-1:0]            limit,
  output logic      [ffca_pkg::AMT_W-1:0]  alu_a,
  output logic      [ffca_pkg::AMT_W-1:0]  alu_b,
  input  wire ffca_pkg::alu_res_t          alu_res,
  output logic                             mem_we,
  output logic      [NODE_W-1:0]           mem_waddr,
  output logic      [ffca_pkg::AMT_W-1:0]  mem_wdata,
  output logic      [NODE_W-1:0]           mem_raddr,
  input  wire logic [ffca_pkg::AMT_W-1:0]  mem_rdata
);

  localparam int LOG_W = NODE_W - 1;
  localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
  localparam logic [NODE_W-1:0] ROOT_LEFT = NODE_W'(2);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_ROOT   = 7'b0000100,
    ST_DOWN   = 7'b0001000,
    ST_LEAF   = 7'b0010000,
    ST_UP     = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [NODE_W-1:0]             cur_r, cur_nxt;
  logic [NODE_W-1:0]             clr_r, clr_nxt;
  logic [ffca_pkg::AMT_W-1:0]    val_r, val_nxt;
  logic [ffca_pkg::AMT_W-1:0]    amt_r, amt_nxt;
  logic                          is_req_r, is_req_nxt;
  logic [ffca_pkg::SLOT_W-1:0]   result_r, result_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ffca_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;

  logic                          in_xfer;
  logic [CMP_W-1:0]              in_slot_ext;
  logic [NODE_W-1:0]             in_leaf;
  logic [CMP_W-1:0]              cur_slot_ext;
  logic [NODE_W-1:0]             child;
  logic [NODE_W-1:0]             parent;

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign in_slot_ext   = CMP_W'(in_ch.slot_index);
  assign in_leaf       = {1'b1, in_slot_ext[LOG_W-1:0]};
  assign cur_slot_ext  = CMP_W'(cur_r[LOG_W-1:0]);
  assign child         = {cur_r[NODE_W-2:0], ~alu_res.ge};
  assign parent        = {1'b0, cur_r[NODE_W-1:1]};

  // Shared unit operands: node read back against amount or carried value
  assign alu_a = mem_rdata;
  assign alu_b = (state_r == ST_UP) ? val_r : amt_r;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.assigned_slot = out_slot_r;

  // Sequencer: clear, descend, update leaf, climb back to the root
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    clr_nxt       = clr_r;
    val_nxt       = val_r;
    amt_nxt       = amt_r;
    is_req_nxt    = is_req_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r;
    out_slot_nxt  = out_slot_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_r;
    mem_wdata     = val_r;
    mem_raddr     = '0;

    // Drop the result once the sink takes the transfer
    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + NODE_W'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          amt_nxt    = in_ch.amount;
          is_req_nxt = in_ch.req_type;
          if (in_ch.req_type == ffca_pkg::REQ_LOAD) begin
            // Write the leaf now and fetch its sibling
            if (in_slot_ext < limit) begin
              mem_we    = 1'b1;
              mem_waddr = in_leaf;
              mem_wdata = in_ch.amount;
              val_nxt   = in_ch.amount;
              cur_nxt   = in_leaf;
              mem_raddr = in_leaf ^ NODE_W'(1);
              state_nxt = ST_UP;
            end
          end else if (in_ch.amount == '0) begin
            result_nxt = '0;
            state_nxt  = ST_FINISH;
          end else begin
            mem_raddr = ROOT_NODE;
            state_nxt = ST_ROOT;
          end
        end
      end

      ST_ROOT: begin
        if (!alu_res.ge) begin
          result_nxt = '0;
          state_nxt  = ST_FINISH;
        end else begin
          cur_nxt   = ROOT_NODE;
          mem_raddr = ROOT_LEFT;
          state_nxt = ST_DOWN;
        end
      end

      ST_DOWN: begin
        // Take the left child if it fits, else the right one
        cur_nxt = child;
        if (child[NODE_W-1]) begin
          mem_raddr = child;
          state_nxt = ST_LEAF;
        end else begin
          mem_raddr = {child[NODE_W-2:0], 1'b0};
        end
      end

      ST_LEAF: begin
        if (cur_slot_ext >= limit) begin
          result_nxt = '0;
          state_nxt  = ST_FINISH;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = cur_r;
          mem_wdata  = alu_res.diff;
          val_nxt    = alu_res.diff;
          result_nxt = ffca_pkg::SLOT_W'(cur_slot_ext + CMP_W'(1));
          mem_raddr  = cur_r ^ NODE_W'(1);
          state_nxt  = ST_UP;
        end
      end

      ST_UP: begin
        // Parent takes the larger of carried value and sibling
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = alu_res.maxv;
        val_nxt   = alu_res.maxv;
        cur_nxt   = parent;
        if (parent == ROOT_NODE) begin
          state_nxt = is_req_r ? ST_FINISH : ST_IDLE;
        end else begin
          mem_raddr = parent ^ NODE_W'(1);
        end
      end

      ST_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = result_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    val_r      <= val_nxt;
    amt_r      <= amt_nxt;
    is_req_r   <= is_req_nxt;
    result_r   <= result_nxt;
    out_slot_r <= out_slot_nxt;
  end

  `FFCA_ASSERT_IMP(a_out_rise, $rose(out_valid_r), $past(state_r) == ST_FINISH, "stray result")
  `FFCA_ASSERT_IMP(a_rw_clash, mem_we && state_r != ST_CLEAR, mem_waddr != mem_raddr, "node clash")
  `FFCA_ASSERT_IMP(a_down_in, state_r == ST_DOWN, cur_r != '0 && !cur_r[NODE_W-1], "bad descent")
  `FFCA_ASSERT_NXT(a_clr_end, state_r == ST_CLEAR && clr_r == '1, state_r == ST_IDLE, "clear stuck")

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_capacity_allocator_core.sv =====
// First-fit capacity allocator over a max tree of per-slot free capacity.
// Channels: in_ch carries items (req_type, slot_index, amount), out_ch carries
// assigned_slot, cfg_ch writes slot_count; every channel moves a transfer when
// valid and ready are both high. cfg_ch is always ready.
// A load (req_type 0) sets one slot's capacity and gives no result; it writes
// the leaf, then climbs to the root. A request (req_type 1) returns the
// one-based lowest slot that fits, or 0, after a root check, a descent to a
// leaf and a climb back up; zero amounts and misses finish early.
// One tree node is read and one written per cycle through a single memory,
// and one subtract/compare unit serves the descent and the climb back up,
// so the block takes one item at a time and is not ready meanwhile.
// Reset: slot_count returns to 1024 and a clearing pass zeroes every tree
// node while in_ch is not ready.
// Stall: a finished result sits in the output register; the next item is
// accepted while it waits, and a second result waits until the first leaves.
`default_nettype none

module first_fit_capacity_allocator_core #(
  parameter int MAX_SLOTS = ffca_pkg::DEF_MAX_SLOTS
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  ffca_cfg_if.sink     cfg_ch,
  ffca_in_if.sink      in_ch,
  ffca_out_if.source   out_ch
);

  localparam int LOG_W  = $clog2(MAX_SLOTS);
  localparam int NODE_W = LOG_W + 1;
  localparam int CMP_W  = (NODE_W > ffca_pkg::CNT_W) ? NODE_W : ffca_pkg::CNT_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_SLOTS);

  logic [ffca_pkg::CNT_W-1:0]  slot_count_r;
  logic [CMP_W-1:0]            cnt_ext;
  logic [CMP_W-1:0]            limit;
  logic [ffca_pkg::AMT_W-1:0]  alu_a;
  logic [ffca_pkg::AMT_W-1:0]  alu_b;
  ffca_pkg::alu_res_t          alu_res;
  logic                        mem_we;
  logic [NODE_W-1:0]           mem_waddr;
  logic [ffca_pkg::AMT_W-1:0]  mem_wdata;
  logic [NODE_W-1:0]           mem_raddr;
  logic [ffca_pkg::AMT_W-1:0]  mem_rdata;

  // Take slot count writes at any time
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= ffca_pkg::CNT_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      slot_count_r <= cfg_ch.slot_count;
    end
  end

  // Clamp the slot count to the tree size
  assign cnt_ext = CMP_W'(slot_count_r);
  assign limit   = (cnt_ext > MAX_CMP) ? MAX_CMP : cnt_ext;

  ffca_ctrl #(
    .MAX_SLOTS (MAX_SLOTS),
    .NODE_W    (NODE_W),
    .CMP_W     (CMP_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .limit     (limit),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_res   (alu_res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ffca_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  ffca_tree_mem #(
    .ADDR_W (NODE_W),
    .DATA_W (ffca_pkg::AMT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
